@@ hw/rtl/drqt_pkg.sv @@
// Shared types and constants for the dense rank query table.
package drqt_pkg;

    localparam int MAX_RECORDS_DEF = 128;
    localparam int ID_W            = 8;
    localparam int SCORE_W         = 8;
    localparam int RANK_W          = 8;
    localparam int OP_W            = 2;
    localparam int REC_W           = ID_W + SCORE_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } drqt_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_Q_REC,
        ST_Q_DIST,
        ST_Q_OUT
    } drqt_state_t;

endpackage

@@ hw/rtl/dense_rank_query_table_unit.sv @@
// Top level of the dense rank query table: record RAM, distinct-score RAM, sequencer.
//
// Input channel s_*: one beat carries s_opcode, s_team_id and s_score.
//   OP_INSERT appends a record (dropped when the table is full) and merges its
//   score into the descending distinct-score list. OP_QUERY returns the dense
//   rank of the oldest record with s_team_id. OP_CLEAR empties both tables.
// Result channel m_*: one beat per query, m_rank and m_found; rank 0 with
//   m_found low when the identifier is unknown.
// Clear and ignored opcodes leave the sequencer idle. During an insert the
//   distinct RAM is read and rewritten in a single ascending pass, one entry
//   per cycle. A query scans the record RAM and then the distinct RAM; both
//   scans run one entry per cycle through the single read port of each RAM.
// s_ready is high only while the sequencer is idle; one item is worked at a time.
// A finished result sits in the output register; a stalled receiver lets inserts
//   and clears go on, but holds the next query in ST_Q_OUT and s_ready low.
// Reset (aresetn low, synchronous) empties both tables and drops any result.
module dense_rank_query_table_unit import drqt_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_opcode,
    input  logic [ID_W-1:0]    s_team_id,
    input  logic [SCORE_W-1:0] s_score,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [RANK_W-1:0]  m_rank,
    output logic               m_found
);

    localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    logic               rec_we, rec_re;
    logic [ADDR_W-1:0]  rec_waddr, rec_raddr;
    logic [REC_W-1:0]   rec_wdata, rec_rdata;
    logic               dist_we, dist_re;
    logic [ADDR_W-1:0]  dist_waddr, dist_raddr;
    logic [SCORE_W-1:0] dist_wdata, dist_rdata;

    drqt_ram #(
        .DATA_W (REC_W),
        .DEPTH  (MAX_RECORDS)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    drqt_ram #(
        .DATA_W (SCORE_W),
        .DEPTH  (MAX_RECORDS)
    ) u_dist_ram (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .re    (dist_re),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    drqt_seq #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_team_id  (s_team_id),
        .s_score    (s_score),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rank     (m_rank),
        .m_found    (m_found),
        .rec_we     (rec_we),
        .rec_waddr  (rec_waddr),
        .rec_wdata  (rec_wdata),
        .rec_re     (rec_re),
        .rec_raddr  (rec_raddr),
        .rec_rdata  (rec_rdata),
        .dist_we    (dist_we),
        .dist_waddr (dist_waddr),
        .dist_wdata (dist_wdata),
        .dist_re    (dist_re),
        .dist_raddr (dist_raddr),
        .dist_rdata (dist_rdata)
    );

endmodule

@@ hw/rtl/drqt_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module drqt_ram import drqt_pkg::*; #(
    parameter int DATA_W = SCORE_W,
    parameter int DEPTH  = MAX_RECORDS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/drqt_seq.sv @@
// Sequencer: record append, sorted distinct-score insertion and rank lookup scans.
module drqt_seq import drqt_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1),
    localparam int RCALC_W = (CNT_W > RANK_W) ? CNT_W : RANK_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_opcode,
    input  logic [ID_W-1:0]    s_team_id,
    input  logic [SCORE_W-1:0] s_score,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [RANK_W-1:0]  m_rank,
    output logic               m_found,
    output logic               rec_we,
    output logic [ADDR_W-1:0]  rec_waddr,
    output logic [REC_W-1:0]   rec_wdata,
    output logic               rec_re,
    output logic [ADDR_W-1:0]  rec_raddr,
    input  logic [REC_W-1:0]   rec_rdata,
    output logic               dist_we,
    output logic [ADDR_W-1:0]  dist_waddr,
    output logic [SCORE_W-1:0] dist_wdata,
    output logic               dist_re,
    output logic [ADDR_W-1:0]  dist_raddr,
    input  logic [SCORE_W-1:0] dist_rdata
);

    drqt_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic [SCORE_W-1:0] key_reg, key_next;
    logic [SCORE_W-1:0] carry_reg, carry_next;
    logic               placed_reg, placed_next;
    logic [CNT_W-1:0]   rc_reg, rc_next;
    logic [CNT_W-1:0]   dc_reg, dc_next;
    logic [RANK_W-1:0]  res_rank_reg, res_rank_next;
    logic               res_found_reg, res_found_next;
    logic               m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]  m_rank_reg, m_rank_next;
    logic               m_found_reg, m_found_next;

    logic               accept;
    drqt_op_t           op;
    logic               rec_full;
    logic               issue_rec, issue_dist;
    logic [ID_W-1:0]    rd_id;
    logic [SCORE_W-1:0] rd_score;
    logic               out_free;
    logic [RCALC_W-1:0] rank_wide;

    assign op         = drqt_op_t'(s_opcode);
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign rec_full   = (rc_reg >= CNT_W'(MAX_RECORDS));
    assign issue_rec  = (idx_reg < rc_reg);
    assign issue_dist = (idx_reg < dc_reg);
    assign rd_id      = rec_rdata[REC_W-1:SCORE_W];
    assign rd_score   = rec_rdata[SCORE_W-1:0];
    assign out_free   = !m_valid_reg || m_ready;
    assign rank_wide  = RCALC_W'(paddr_reg) + RCALC_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_QUERY) begin
                    state_next = ST_Q_REC;
                end else if (accept && op == OP_INSERT && !rec_full) begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                if (pend_reg && !placed_reg && dist_rdata == key_reg) begin
                    state_next = ST_IDLE;
                end else if (!issue_dist && !pend_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_REC: begin
                if (pend_reg && rd_id == key_reg) begin
                    state_next = ST_Q_DIST;
                end else if (!issue_rec && !pend_reg) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_DIST: begin
                if (pend_reg && dist_rdata == key_reg) begin
                    state_next = ST_Q_OUT;
                end else if (!issue_dist && !pend_reg) begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        paddr_next     = paddr_reg;
        key_next       = key_reg;
        carry_next     = carry_reg;
        placed_next    = placed_reg;
        rc_next        = rc_reg;
        dc_next        = dc_reg;
        res_rank_next  = res_rank_reg;
        res_found_next = res_found_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_rank_next    = m_rank_reg;
        m_found_next   = m_found_reg;
        rec_we         = 1'b0;
        rec_waddr      = rc_reg[ADDR_W-1:0];
        rec_wdata      = {s_team_id, s_score};
        rec_re         = 1'b0;
        rec_raddr      = idx_reg[ADDR_W-1:0];
        dist_we        = 1'b0;
        dist_waddr     = paddr_reg;
        dist_wdata     = key_reg;
        dist_re        = 1'b0;
        dist_raddr     = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                idx_next    = '0;
                placed_next = 1'b0;
                if (accept) begin
                    case (op)
                        OP_INSERT: begin
                            key_next = s_score;
                            if (!rec_full) begin
                                rec_we  = 1'b1;
                                rc_next = rc_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY: key_next = s_team_id;
                        OP_CLEAR: begin
                            rc_next = '0;
                            dc_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS: begin
                if (issue_dist) begin
                    dist_re    = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    if (placed_reg) begin
                        // ripple the tail of the list up by one entry
                        dist_we    = 1'b1;
                        dist_wdata = carry_reg;
                        carry_next = dist_rdata;
                    end else if (dist_rdata < key_reg) begin
                        dist_we     = 1'b1;
                        dist_wdata  = key_reg;
                        carry_next  = dist_rdata;
                        placed_next = 1'b1;
                    end
                end else if (!issue_dist) begin
                    dist_we    = 1'b1;
                    dist_waddr = dc_reg[ADDR_W-1:0];
                    dist_wdata = placed_reg ? carry_reg : key_reg;
                    dc_next    = dc_reg + CNT_W'(1);
                end
            end
            ST_Q_REC: begin
                if (issue_rec) begin
                    rec_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + CNT_W'(1);
                end
                if (pend_reg && rd_id == key_reg) begin
                    key_next  = rd_score;
                    idx_next  = '0;
                    pend_next = 1'b0;
                end else if (!pend_reg && !issue_rec) begin
                    res_rank_next  = '0;
                    res_found_next = 1'b0;
                end
            end
            ST_Q_DIST: begin
                if (issue_dist) begin
                    dist_re    = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + CNT_W'(1);
                end
                if (pend_reg && dist_rdata == key_reg) begin
                    res_rank_next  = rank_wide[RANK_W-1:0];
                    res_found_next = 1'b1;
                end else if (!pend_reg && !issue_dist) begin
                    res_rank_next  = '0;
                    res_found_next = 1'b0;
                end
            end
            ST_Q_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rank_next  = res_rank_reg;
                    m_found_next = res_found_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            placed_reg  <= 1'b0;
            rc_reg      <= '0;
            dc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            placed_reg  <= placed_next;
            rc_reg      <= rc_next;
            dc_reg      <= dc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        paddr_reg     <= paddr_next;
        key_reg       <= key_next;
        carry_reg     <= carry_next;
        res_rank_reg  <= res_rank_next;
        res_found_reg <= res_found_next;
        m_rank_reg    <= m_rank_next;
        m_found_reg   <= m_found_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rank  = m_rank_reg;
    assign m_found = m_found_reg;

endmodule
